@@ rtl/prc_pkg.sv @@
// Shared types, constants and helper functions for the polygon ray cast block.
package prc_pkg;

   localparam int MaxPointsDefault = 64;
   localparam int FracBitsDefault = 8;
   localparam int CoordWidth = 24;
   localparam int DistWidth = 32;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic [CsrAddrWidth-1:0] AddrBodyX = 3'd0;
   localparam logic [CsrAddrWidth-1:0] AddrBodyY = 3'd4;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_CAST  = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;       // empty store and reset extrema
      logic add;         // write point and update extrema
      logic full_flag;   // register the store-full flag
      logic cast_start;  // latch ray and clear hit state
      logic rd_issue;    // issue store reads for the current edge
      logic edge_load;   // compute edge vectors for the loaded edge
      logic edge_eval;   // sign checks and first divider start
      logic frac_start;  // start the fraction division
      logic edge_done;   // fold the edge's t into the best hit
      logic out_load;    // load the result register
   } prc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic store_full;
      logic edge_skip;
      logic div_busy;
      logic quot_big;
   } prc_status_type;

   // Saturate a 26-bit signed value to 24 signed bits.
   function automatic logic signed [CoordWidth-1:0] sat_s24(input logic signed [25:0] v);
      logic signed [CoordWidth-1:0] r;
      if (v > 26'sd8388607) r = 24'sh7FFFFF;
      else if (v < -26'sd8388608) r = 24'sh800000;
      else r = v[CoordWidth-1:0];
      return r;
   endfunction

   // Saturate a 26-bit signed value to 24 unsigned bits.
   function automatic logic [CoordWidth-1:0] sat_u24(input logic signed [25:0] v);
      logic [CoordWidth-1:0] r;
      if (v > 26'sd16777215) r = 24'hFFFFFF;
      else if (v < 26'sd0) r = 24'h000000;
      else r = v[CoordWidth-1:0];
      return r;
   endfunction

endpackage

@@ rtl/prc_req_if.sv @@
// Valid/ready channel interfaces for request and response beats.
interface prc_req_if;
   logic valid;
   logic ready;
   logic [1:0] req_type;
   logic signed [prc_pkg::CoordWidth-1:0] point_x;
   logic signed [prc_pkg::CoordWidth-1:0] point_y;
   logic signed [prc_pkg::CoordWidth-1:0] ray_x;
   logic signed [prc_pkg::CoordWidth-1:0] ray_y;
   logic signed [prc_pkg::CoordWidth-1:0] dir_x;
   logic signed [prc_pkg::CoordWidth-1:0] dir_y;
   modport source (output valid, req_type, point_x, point_y, ray_x, ray_y, dir_x, dir_y,
                   input ready);
   modport sink (input valid, req_type, point_x, point_y, ray_x, ray_y, dir_x, dir_y,
                 output ready);
endinterface

interface prc_rsp_if;
   logic valid;
   logic ready;
   logic [prc_pkg::DistWidth-1:0] hit_distance;
   logic hit_found;
   logic store_full;
   logic signed [prc_pkg::CoordWidth-1:0] box_left;
   logic signed [prc_pkg::CoordWidth-1:0] box_top;
   logic [prc_pkg::CoordWidth-1:0] box_width;
   logic [prc_pkg::CoordWidth-1:0] box_height;
   modport source (output valid, hit_distance, hit_found, store_full, box_left, box_top,
                   box_width, box_height, input ready);
   modport sink (input valid, hit_distance, hit_found, store_full, box_left, box_top,
                 box_width, box_height, output ready);
endinterface

@@ rtl/polygon_ray_cast_with_bounds.sv @@
// Top level of the polygon ray cast block with bounding box.
// One request is in flight at a time, and a new beat is taken only once the previous
// response beat has left. A no-op loads its response at the accepting edge; clear, add
// and a ray cast on fewer than two points load theirs from ST_OUT in the cycle after. A
// ray cast walks the closed polygon one edge per pass through RD0, RD1, VEC, PROD and
// EVAL; an edge that is parallel or misses goes on to NEXT, and one that hits waits in
// DIV1 and DIV2 for the shared restoring divider, which runs 64 steps for the integer
// part of t and 64 more for its fraction. The store holds up to 64 points. Body
// registers sit at byte addresses 0 and 4 of the csr port.
module polygon_ray_cast_with_bounds #(
   parameter int MaxPoints = prc_pkg::MaxPointsDefault,
   parameter int FracBits = prc_pkg::FracBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   prc_req_if.sink                           req,
   prc_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [prc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [prc_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [prc_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   logic signed [prc_pkg::CoordWidth-1:0] body_x_ff, body_y_ff;
   prc_pkg::prc_cmd_type                  cmd;
   prc_pkg::prc_status_type               status;
   logic [$clog2(MaxPoints)-1:0]          edge_idx;
   logic [$clog2(MaxPoints+1)-1:0]        count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         body_x_ff <= '0;
         body_y_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == prc_pkg::AddrBodyX) body_x_ff <= csr_pwdata[23:0];
         if (csr_paddr == prc_pkg::AddrBodyY) body_y_ff <= csr_pwdata[23:0];
      end
   end

   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr)
         prc_pkg::AddrBodyX: csr_prdata = {{8{body_x_ff[23]}}, body_x_ff};
         prc_pkg::AddrBodyY: csr_prdata = {{8{body_y_ff[23]}}, body_y_ff};
         default:            csr_prdata = '0;
      endcase
   end

   prc_controller #(.MaxPoints(MaxPoints)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_code(req.req_type),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .status(status),
      .cmd(cmd),
      .edge_idx(edge_idx),
      .count(count)
   );

   prc_datapath #(.MaxPoints(MaxPoints), .FracBits(FracBits)) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .edge_idx(edge_idx),
      .count(count),
      .body_x(body_x_ff),
      .body_y(body_y_ff),
      .req(req),
      .rsp(rsp)
   );
endmodule

@@ rtl/prc_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module prc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/prc_divider.sv @@
// Restoring radix-2 divider: one quotient bit per cycle.
module prc_divider #(
   parameter int NumWidth = 64,
   parameter int QuoWidth = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumWidth-1:0] dividend,
   input  logic [NumWidth-1:0] divisor,
   output logic                busy,
   output logic [QuoWidth-1:0] quotient,
   output logic [NumWidth-1:0] remainder
);
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] rem_ff, rem_in;
   logic [NumWidth-1:0] num_ff, num_in;
   logic [NumWidth-1:0] den_ff, den_in;
   logic [QuoWidth-1:0] quo_ff, quo_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [NumWidth:0]   trial;
   logic [NumWidth:0]   shifted;

   // One shift-subtract step per cycle over all dividend bits.
   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, num_ff[NumWidth-1]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
         quo_in  = '0;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumWidth-2:0], 1'b0};
         if (!trial[NumWidth]) begin
            rem_in = trial[NumWidth-1:0];
            quo_in = {quo_ff[QuoWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[NumWidth-1:0];
            quo_in = {quo_ff[QuoWidth-2:0], 1'b0};
         end
         // Sticky top bit marks quotients too large for the register.
         if (quo_ff[QuoWidth-1]) quo_in[QuoWidth-1] = 1'b1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

@@ rtl/prc_datapath.sv @@
// Datapath: point store, extrema, edge arithmetic, divider and result register.
module prc_datapath #(
   parameter int MaxPoints = prc_pkg::MaxPointsDefault,
   parameter int FracBits = prc_pkg::FracBitsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  prc_pkg::prc_cmd_type                  cmd,
   output prc_pkg::prc_status_type               status,
   input  logic [$clog2(MaxPoints)-1:0]          edge_idx,
   input  logic [$clog2(MaxPoints+1)-1:0]        count,
   input  logic signed [prc_pkg::CoordWidth-1:0] body_x,
   input  logic signed [prc_pkg::CoordWidth-1:0] body_y,
   prc_req_if.sink                               req,
   prc_rsp_if.source                             rsp
);
   localparam int CW = prc_pkg::CoordWidth;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);
   localparam int DivW = 64;
   localparam logic signed [25:0] Unit = 26'sd1 <<< FracBits;

   // Extrema of stored points.
   logic signed [CW-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic signed [CW-1:0] ray_x_ff, ray_y_ff, dir_x_ff, dir_y_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         min_x_ff <= '0;
         min_y_ff <= '0;
         max_x_ff <= '0;
         max_y_ff <= '0;
      end else if (cmd.add) begin
         if (req.point_x < min_x_ff) min_x_ff <= req.point_x;
         if (req.point_y < min_y_ff) min_y_ff <= req.point_y;
         if (req.point_x > max_x_ff) max_x_ff <= req.point_x;
         if (req.point_y > max_y_ff) max_y_ff <= req.point_y;
      end
      if (cmd.cast_start) begin
         ray_x_ff <= req.ray_x;
         ray_y_ff <= req.ray_y;
         dir_x_ff <= req.dir_x;
         dir_y_ff <= req.dir_y;
      end
   end

   // Two reads per edge go through one port: point i, then point j.
   logic [IdxW-1:0] next_idx;
   logic [IdxW-1:0] rd_addr;
   logic            rd_second_ff;
   logic [2*CW-1:0] rd_data;
   logic [2*CW-1:0] pi_ff;

   assign next_idx = ({1'b0, edge_idx} + 1'b1 >= (IdxW+1)'(count)) ? '0 : edge_idx + 1'b1;
   assign rd_addr  = rd_second_ff ? next_idx : edge_idx;

   prc_ram #(.Width(2*CW), .Depth(MaxPoints)) u_store (
      .clock(clock),
      .wr_en(cmd.add),
      .wr_addr(count[IdxW-1:0]),
      .wr_data({req.point_x, req.point_y}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) rd_second_ff <= 1'b0;
      else if (cmd.rd_issue) rd_second_ff <= 1'b1;
      else rd_second_ff <= 1'b0;
      if (rd_second_ff) pi_ff <= rd_data;
   end

   // Edge vectors, registered before the products; v1 takes two subtracts, v2 one.
   logic signed [CW+2:0] v1x_ff, v1y_ff;
   logic signed [CW:0]   v2x_ff, v2y_ff;
   logic signed [CW-1:0] pix, piy, pjx, pjy;

   assign pix = pi_ff[2*CW-1:CW];
   assign piy = pi_ff[CW-1:0];
   assign pjx = rd_data[2*CW-1:CW];
   assign pjy = rd_data[CW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.edge_load) begin
         v1x_ff <= (CW+3)'(ray_x_ff) - (CW+3)'(body_x) - (CW+3)'(pix);
         v1y_ff <= (CW+3)'(ray_y_ff) - (CW+3)'(body_y) - (CW+3)'(piy);
         v2x_ff <= (CW+1)'(pjx) - (CW+1)'(pix);
         v2y_ff <= (CW+1)'(pjy) - (CW+1)'(piy);
      end
   end

   // Products, registered; then sums. v3 = (-dy, dx).
   logic signed [2*CW+3:0] p_a_ff, p_b_ff, p_c_ff, p_d_ff, p_e_ff, p_f_ff;
   logic signed [CW:0]     v3x, v3y;
   logic                   prod_ff;

   assign v3x = -(CW+1)'(dir_y_ff);
   assign v3y = (CW+1)'(dir_x_ff);

   always_ff @(posedge clock) begin
      if (reset) prod_ff <= 1'b0;
      else prod_ff <= cmd.edge_load;
      if (prod_ff) begin
         p_a_ff <= (2*CW+4)'(v2x_ff * v3x);
         p_b_ff <= (2*CW+4)'(v2y_ff * v3y);
         p_c_ff <= (2*CW+4)'(v2x_ff * v1y_ff);
         p_d_ff <= (2*CW+4)'(v2y_ff * v1x_ff);
         p_e_ff <= (2*CW+4)'(v1x_ff * v3x);
         p_f_ff <= (2*CW+4)'(v1y_ff * v3y);
      end
   end

   logic signed [2*CW+4:0] den_s, n1_s, n2_s;
   logic signed [2*CW+4:0] den_a, n1_a, n2_a;
   logic                   skip;

   assign den_s = (2*CW+5)'(p_a_ff) + (2*CW+5)'(p_b_ff);
   assign n1_s  = (2*CW+5)'(p_c_ff) - (2*CW+5)'(p_d_ff);
   assign n2_s  = (2*CW+5)'(p_e_ff) + (2*CW+5)'(p_f_ff);
   assign den_a = den_s[2*CW+4] ? -den_s : den_s;
   assign n1_a  = den_s[2*CW+4] ? -n1_s : n1_s;
   assign n2_a  = den_s[2*CW+4] ? -n2_s : n2_s;
   assign skip  = (den_s == '0) || n1_a[2*CW+4] || n2_a[2*CW+4] || (n2_a > den_a);

   // Divider shared by the integer and fraction steps.
   logic [DivW-1:0] den_ff;
   logic            div_start;
   logic [DivW-1:0] div_num;
   logic [16:0]     quo;
   logic [DivW-1:0] rem;
   logic            div_busy;
   logic [15:0]     t_int_ff;
   logic [DivW-1:0] frac_num;

   assign frac_num  = {rem[DivW-17:0], 16'd0};
   assign div_start = cmd.edge_eval | cmd.frac_start;
   assign div_num   = cmd.frac_start ? frac_num : DivW'(n1_a);

   always_ff @(posedge clock) begin
      if (cmd.edge_eval) den_ff <= DivW'(den_a);
      if (cmd.frac_start) t_int_ff <= quo[15:0];
   end

   prc_divider #(.NumWidth(DivW), .QuoWidth(17)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_num),
      .divisor(cmd.frac_start ? den_ff : DivW'(den_a)),
      .busy(div_busy),
      .quotient(quo),
      .remainder(rem)
   );

   // Best hit so far.
   logic [prc_pkg::DistWidth-1:0] best_ff;
   logic                          found_ff;
   logic [prc_pkg::DistWidth-1:0] t_edge;
   logic                          big_ff;

   always_ff @(posedge clock) begin
      if (cmd.edge_eval) big_ff <= 1'b0;
      else if (cmd.frac_start) big_ff <= quo[16];
   end

   assign t_edge = big_ff ? 32'hFFFFFFFF : {t_int_ff, quo[15:0]};

   always_ff @(posedge clock) begin
      if (reset || cmd.cast_start) begin
         best_ff  <= 32'hFFFFFFFF;
         found_ff <= 1'b0;
      end else if (cmd.edge_done) begin
         found_ff <= 1'b1;
         if (t_edge < best_ff) best_ff <= t_edge;
      end
   end

   // Result register.
   logic                          out_valid_ff;
   logic [prc_pkg::DistWidth-1:0] dist_ff;
   logic                          hit_ff, full_ff, cast_ff;
   logic signed [CW-1:0]          left_ff, top_ff;
   logic [CW-1:0]                 width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) cast_ff <= 1'b0;
      else if (cmd.cast_start) cast_ff <= 1'b1;
      else if (cmd.clear || cmd.add || cmd.full_flag) cast_ff <= 1'b0;
      else if (cmd.out_load) cast_ff <= 1'b0;
   end

   logic full_sel_ff;
   always_ff @(posedge clock) begin
      if (reset) full_sel_ff <= 1'b0;
      else if (cmd.full_flag) full_sel_ff <= 1'b1;
      else if (cmd.clear || cmd.add || cmd.cast_start || cmd.out_load) full_sel_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (rsp.ready) out_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         dist_ff   <= (cast_ff && found_ff) ? best_ff : '0;
         hit_ff    <= cast_ff && found_ff;
         full_ff   <= full_sel_ff;
         left_ff   <= prc_pkg::sat_s24(26'(min_x_ff) + 26'(body_x) - Unit);
         top_ff    <= prc_pkg::sat_s24(26'(min_y_ff) + 26'(body_y) - Unit);
         width_ff  <= prc_pkg::sat_u24(26'(max_x_ff) - 26'(min_x_ff) + (Unit <<< 1));
         height_ff <= prc_pkg::sat_u24(26'(max_y_ff) - 26'(min_y_ff) + (Unit <<< 1));
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.hit_distance = dist_ff;
   assign rsp.hit_found    = hit_ff;
   assign rsp.store_full   = full_ff;
   assign rsp.box_left     = left_ff;
   assign rsp.box_top      = top_ff;
   assign rsp.box_width    = width_ff;
   assign rsp.box_height   = height_ff;

   assign status.store_full = (count == CntW'(MaxPoints));
   assign status.edge_skip  = skip;
   assign status.div_busy   = div_busy;
   assign status.quot_big   = quo[16];
endmodule

@@ rtl/prc_controller.sv @@
// Controller: request decode, point count and edge sequencing.
module prc_controller #(
   parameter int MaxPoints = prc_pkg::MaxPointsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_code,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  prc_pkg::prc_status_type        status,
   output prc_pkg::prc_cmd_type           cmd,
   output logic [$clog2(MaxPoints)-1:0]   edge_idx,
   output logic [$clog2(MaxPoints+1)-1:0] count
);
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = $clog2(MaxPoints + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_VEC, ST_PROD, ST_EVAL, ST_DIV1, ST_DIV2,
      ST_DONE, ST_NEXT, ST_OUT
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            accept;

   // Accept a new request only when idle and the result register is free.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_code)
                  prc_pkg::REQ_CLEAR: begin
                     cmd.clear = 1'b1;
                     count_in  = '0;
                     state_in  = ST_OUT;
                  end
                  prc_pkg::REQ_ADD: begin
                     if (status.store_full) begin
                        cmd.full_flag = 1'b1;
                     end else begin
                        cmd.add  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     state_in = ST_OUT;
                  end
                  prc_pkg::REQ_CAST: begin
                     cmd.cast_start = 1'b1;
                     idx_in         = '0;
                     state_in       = (count_ff >= CntW'(2)) ? ST_RD0 : ST_OUT;
                  end
                  default: begin
                     cmd.out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_RD0: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RD1;
         end
         ST_RD1: state_in = ST_VEC;
         ST_VEC: begin
            cmd.edge_load = 1'b1;
            state_in      = ST_PROD;
         end
         ST_PROD: state_in = ST_EVAL;
         ST_EVAL: begin
            if (status.edge_skip) begin
               state_in = ST_NEXT;
            end else begin
               cmd.edge_eval = 1'b1;
               state_in      = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (!status.div_busy) begin
               cmd.frac_start = 1'b1;
               state_in       = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (!status.div_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.edge_done = 1'b1;
            state_in      = ST_NEXT;
         end
         ST_NEXT: begin
            if ({1'b0, idx_ff} + 1'b1 >= (IdxW+1)'(count_ff)) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RD0;
            end
         end
         ST_OUT: begin
            cmd.out_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   assign edge_idx = idx_ff;
   assign count    = count_ff;
endmodule

@@ tb/sv/polygon_ray_cast_with_bounds_tb.sv @@
// Self-checking testbench for the polygon ray cast block with bounding box.
`timescale 1ns / 1ps

module polygon_ray_cast_with_bounds_tb;

   localparam int StoreDepth = prc_pkg::MaxPointsDefault;
   localparam longint Unit = longint'(1) << prc_pkg::FracBitsDefault;
   localparam int StallLimit = 60000;
   localparam int HoldOffCycles = 1500;

   typedef struct packed {
      prc_pkg::req_code_type kind;
      logic signed [prc_pkg::CoordWidth-1:0] px;
      logic signed [prc_pkg::CoordWidth-1:0] py;
      logic signed [prc_pkg::CoordWidth-1:0] rx;
      logic signed [prc_pkg::CoordWidth-1:0] ry;
      logic signed [prc_pkg::CoordWidth-1:0] dx;
      logic signed [prc_pkg::CoordWidth-1:0] dy;
   } shape_req_type;

   typedef struct packed {
      logic [prc_pkg::DistWidth-1:0] distance;
      logic found;
      logic full;
      logic [prc_pkg::CoordWidth-1:0] left;
      logic [prc_pkg::CoordWidth-1:0] top;
      logic [prc_pkg::CoordWidth-1:0] width;
      logic [prc_pkg::CoordWidth-1:0] height;
   } shape_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [prc_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [prc_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [prc_pkg::CsrDataWidth-1:0] csr_prdata;
   logic csr_pready;

   prc_req_if req_ch ();
   prc_rsp_if rsp_ch ();

   polygon_ray_cast_with_bounds uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow of the block's state.
   longint shadow_px [StoreDepth];
   longint shadow_py [StoreDepth];
   int shadow_count = 0;
   longint ext_min_x = 0, ext_min_y = 0, ext_max_x = 0, ext_max_y = 0;
   longint body_x = 0, body_y = 0;

   shape_req_type pending_q[$];
   shape_rsp_type expected_q[$];
   int send_idle_pct = 22;
   int recv_idle_pct = 65;
   int hold_asked = 0;
   int errors = 0;
   int casts_seen = 0, hits_seen = 0, fulls_seen = 0, beats_out = 0;
   logic req_beat = 1'b0;
   int stall_cycles = 0;

   // Clock generation.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint clamp_s24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint clamp_u24(longint v);
      if (v > 64'sd16777215) return 64'sd16777215;
      if (v < 0) return 0;
      return v;
   endfunction

   // Nearest hit of the ray against the closed polygon, as Q16.16.
   function automatic logic [prc_pkg::DistWidth-1:0] nearest_hit(longint ox, longint oy,
                                                                longint ddx, longint ddy,
                                                                output logic found);
      logic [63:0] best, q, r, t, uden;
      longint v1x, v1y, v2x, v2y, den, n1, n2;
      int j;
      best = 64'hFFFF_FFFF;
      found = 1'b0;
      for (int i = 0; i < shadow_count; i++) begin
         j = (i + 1 >= shadow_count) ? 0 : i + 1;
         v1x = ox - body_x - shadow_px[i];
         v1y = oy - body_y - shadow_py[i];
         v2x = shadow_px[j] - shadow_px[i];
         v2y = shadow_py[j] - shadow_py[i];
         den = v2x * (-ddy) + v2y * ddx;
         n1 = v2x * v1y - v2y * v1x;
         n2 = v1x * (-ddy) + v1y * ddx;
         if (den == 0) continue;
         if (den < 0) begin
            den = -den;
            n1 = -n1;
            n2 = -n2;
         end
         if (n1 < 0 || n2 < 0 || n2 > den) continue;
         uden = den;
         q = 64'(n1) / uden;
         r = 64'(n1) % uden;
         if (q >= 64'd65536) t = 64'hFFFF_FFFF;
         else t = (q << 16) | ((r << 16) / uden);
         found = 1'b1;
         if (t < best) best = {32'd0, t[31:0]};
      end
      return found ? best[31:0] : '0;
   endfunction

   // Apply one accepted request to the shadow state and queue its result.
   function automatic void predict_shape(shape_req_type it);
      shape_rsp_type res;
      longint x, y;
      res = '0;
      case (it.kind)
         prc_pkg::REQ_CLEAR: begin
            shadow_count = 0;
            ext_min_x = 0;
            ext_min_y = 0;
            ext_max_x = 0;
            ext_max_y = 0;
         end
         prc_pkg::REQ_ADD: begin
            if (shadow_count >= StoreDepth) begin
               res.full = 1'b1;
            end else begin
               x = $signed(it.px);
               y = $signed(it.py);
               shadow_px[shadow_count] = x;
               shadow_py[shadow_count] = y;
               shadow_count++;
               if (x < ext_min_x) ext_min_x = x;
               if (y < ext_min_y) ext_min_y = y;
               if (x > ext_max_x) ext_max_x = x;
               if (y > ext_max_y) ext_max_y = y;
            end
         end
         prc_pkg::REQ_CAST: begin
            res.distance = nearest_hit($signed(it.rx), $signed(it.ry), $signed(it.dx),
                                       $signed(it.dy), res.found);
         end
         default: ;
      endcase
      res.left = 24'(clamp_s24(ext_min_x + body_x - Unit));
      res.top = 24'(clamp_s24(ext_min_y + body_y - Unit));
      res.width = 24'(clamp_u24(ext_max_x - ext_min_x + 2 * Unit));
      res.height = 24'(clamp_u24(ext_max_y - ext_min_y + 2 * Unit));
      expected_q = {expected_q, res};
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // Request driver: offers queued beats at the falling edge.
   always @(negedge clock) begin
      shape_req_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_beat) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_q.pop_front();
            req_ch.req_type <= it.kind;
            req_ch.point_x <= it.px;
            req_ch.point_y <= it.py;
            req_ch.ray_x <= it.rx;
            req_ch.ray_y <= it.ry;
            req_ch.dir_x <= it.dx;
            req_ch.dir_y <= it.dy;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stalls plus an occasional long hold-off.
   always @(negedge clock) begin
      static int hold_left = 0;
      static int hold_served = 0;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = HoldOffCycles;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on request beats, check response beats.
   always @(posedge clock) begin
      shape_req_type it;
      shape_rsp_type want;
      if (reset) begin
         req_beat <= 1'b0;
      end else begin
         req_beat <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            it.kind = prc_pkg::req_code_type'(req_ch.req_type);
            it.px = req_ch.point_x;
            it.py = req_ch.point_y;
            it.rx = req_ch.ray_x;
            it.ry = req_ch.ray_y;
            it.dx = req_ch.dir_x;
            it.dy = req_ch.dir_y;
            predict_shape(it);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_out++;
            if (expected_q.size() == 0) begin
               $error("Response beat arrived with no request outstanding");
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.hit_found) hits_seen++;
               if (rsp_ch.store_full) fulls_seen++;
               check_field("hit_distance", want.distance, rsp_ch.hit_distance);
               check_field("hit_found", want.found, rsp_ch.hit_found);
               check_field("store_full", want.full, rsp_ch.store_full);
               check_field("box_left", $signed(want.left), rsp_ch.box_left);
               check_field("box_top", $signed(want.top), rsp_ch.box_top);
               check_field("box_width", want.width, rsp_ch.box_width);
               check_field("box_height", want.height, rsp_ch.box_height);
            end
         end
      end
   end

   // Watchdog on cycles without any beat.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("Watchdog expired after %0d idle cycles", stall_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Register write over the csr port, setup then access cycle.
   task automatic csr_write(logic [prc_pkg::CsrAddrWidth-1:0] addr,
                            logic [prc_pkg::CoordWidth-1:0] value);
      logic [prc_pkg::CsrDataWidth-1:0] word;
      word = {8'($urandom_range(255)), value};
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == prc_pkg::AddrBodyX) body_x = $signed(value);
      else if (addr == prc_pkg::AddrBodyY) body_y = $signed(value);
   endtask

   task automatic set_body(logic [prc_pkg::CoordWidth-1:0] bx,
                           logic [prc_pkg::CoordWidth-1:0] by);
      csr_write(prc_pkg::AddrBodyX, bx);
      csr_write(prc_pkg::AddrBodyY, by);
   endtask

   function automatic logic [prc_pkg::CoordWidth-1:0] any24();
      return 24'($urandom());
   endfunction

   function automatic logic [prc_pkg::CoordWidth-1:0] near24(int span);
      return 24'($urandom_range(0, 2 * span) - span);
   endfunction

   task automatic queue_req(prc_pkg::req_code_type kind, logic [prc_pkg::CoordWidth-1:0] px,
                            logic [prc_pkg::CoordWidth-1:0] py,
                            logic [prc_pkg::CoordWidth-1:0] rx,
                            logic [prc_pkg::CoordWidth-1:0] ry,
                            logic [prc_pkg::CoordWidth-1:0] dx,
                            logic [prc_pkg::CoordWidth-1:0] dy);
      shape_req_type it;
      it.kind = kind;
      it.px = px;
      it.py = py;
      it.rx = rx;
      it.ry = ry;
      it.dx = dx;
      it.dy = dy;
      pending_q = {pending_q, it};
      if (kind == prc_pkg::REQ_CAST) casts_seen++;
   endtask

   // A ray from near the body origin, where most polygons enclose it.
   task automatic queue_cast_near();
      queue_req(prc_pkg::REQ_CAST, any24(), any24(), 24'(body_x) + near24(300),
                24'(body_y) + near24(300), near24(4000), near24(4000));
   endtask

   // Random part: mostly clear, build a polygon, cast; some noise.
   task automatic queue_random(int count);
      int n;
      int made;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) < 8) begin
            queue_req(prc_pkg::REQ_CLEAR, any24(), any24(), any24(), any24(), any24(),
                      any24());
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int k = 0; k < n; k++)
               queue_req(prc_pkg::REQ_ADD, near24(2500), near24(2500), any24(), any24(),
                         any24(), any24());
            for (int k = $urandom_range(1, 3); k > 0; k--) queue_cast_near();
            made += n + 3;
         end else begin
            queue_req(prc_pkg::req_code_type'($urandom_range(3)), any24(), any24(), any24(),
                      any24(), any24(), any24());
            made++;
         end
      end
   endtask

   // Let everything drain, then allow the block to settle.
   task automatic drain();
      wait (pending_q.size() == 0 && !req_ch.valid && expected_q.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.ray_x = '0;
      req_ch.ray_y = '0;
      req_ch.dir_x = '0;
      req_ch.dir_y = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_body('0, '0);

      // Directed: empty store, single point, extremes, parallel and large t.
      queue_req(prc_pkg::REQ_CAST, '0, '0, '0, '0, 24'sd256, '0);
      queue_req(prc_pkg::REQ_ADD, 24'h7FFFFF, 24'h800000, '0, '0, '0, '0);
      queue_req(prc_pkg::REQ_CAST, '0, '0, '0, '0, 24'sd256, 24'sd256);
      queue_req(prc_pkg::REQ_ADD, 24'h800000, 24'h7FFFFF, '0, '0, '0, '0);
      queue_req(prc_pkg::REQ_CAST, '0, '0, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
      queue_req(prc_pkg::REQ_NOP, any24(), any24(), any24(), any24(), any24(), any24());
      queue_req(prc_pkg::REQ_CLEAR, '0, '0, '0, '0, '0, '0);
      queue_req(prc_pkg::REQ_ADD, '0, '0, '0, '0, '0, '0);
      queue_req(prc_pkg::REQ_ADD, 24'sd2560, '0, '0, '0, '0, '0);
      queue_req(prc_pkg::REQ_ADD, 24'sd2560, '0, '0, '0, '0, '0);
      queue_req(prc_pkg::REQ_CAST, '0, '0, 24'sd1280, -24'sd8000000, '0, 24'sd1);
      queue_req(prc_pkg::REQ_CAST, '0, '0, 24'sd1280, 24'sd512, '0, '0);
      queue_req(prc_pkg::REQ_CAST, '0, '0, 24'sd1280, 24'sd512, 24'sd256, '0);
      queue_req(prc_pkg::REQ_CLEAR, '0, '0, '0, '0, '0, '0);
      for (int k = 0; k < StoreDepth; k++)
         queue_req(prc_pkg::REQ_ADD, near24(3000), near24(3000), '0, '0, '0, '0);
      queue_req(prc_pkg::REQ_ADD, 24'sd100, 24'sd100, '0, '0, '0, '0);
      queue_cast_near();
      queue_cast_near();
      queue_random(60);
      drain();

      // Sender-heavy idling, with the body at opposite extremes and then near the origin.
      send_idle_pct = 65;
      recv_idle_pct = 22;
      set_body(24'h7FFFFF, 24'h800000);
      queue_random(30);
      drain();
      set_body(near24(20000), near24(20000));
      queue_random(40);
      drain();

      // No idling, then a long receiver hold-off while requests keep coming.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_body(24'h800000, 24'h7FFFFF);
      queue_random(25);
      hold_asked++;
      drain();
      set_body('0, '0);
      queue_random(15);
      drain();

      $display("Covered %0d response beats, %0d ray casts with %0d hits,", beats_out,
               casts_seen, hits_seen);
      $display("and %0d rejected adds, across five body settings.", fulls_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
